// ===== hw/rtl/gbts_pkg.sv =====
// package: request and result types and operation codes for the gap buffer text store
`default_nettype none
package gbts_pkg;

  localparam logic [2:0] OpInsert  = 3'd0;
  localparam logic [2:0] OpDelete  = 3'd1;
  localparam logic [2:0] OpRead    = 3'd2;
  localparam logic [2:0] OpFindFwd = 3'd3;
  localparam logic [2:0] OpFindRev = 3'd4;
  localparam logic [2:0] OpClear   = 3'd5;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StBeyond = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [12:0] pos;
    logic [12:0] range_end;
    logic [7:0]  byte_in;
  } gbts_req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [12:0] found_pos;
    logic        found;
    logic [12:0] text_length;
    logic [1:0]  status;
  } gbts_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gbts_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module gbts_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/gap_buffer_text_store.sv =====
// top level: gap buffer text store with a single byte memory and a move sequencer
// usage:
//   requests enter on req (valid/stall); one result per request leaves on rsp.
//   insert and delete first slide the gap to the position, moving one byte
//   per read then write of the single-port memory (SMoveR, SMoveW), then
//   apply the edit. a read past the end skips the memory read. searches read
//   one byte per cycle. rejected inserts, empty deletes, clear and other ops
//   give their result without a memory access.
//   one request is in work at a time; the next is taken only once the
//   receiver takes the pending result, at the earliest in that same cycle.
//   req_stall_o is high while a request is in work or the output is stalled.
//   reset empties the text (gap covers the whole store) and drops any result.
//   the stored bytes are not cleared; a gap byte is never returned.
`default_nettype none
module gap_buffer_text_store
  import gbts_pkg::*;
#(
  parameter int Capacity = 4096
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_stall_o,
  input  wire gbts_req_t req_i,
  output logic           rsp_valid_o,
  input  wire logic      rsp_stall_i,
  output gbts_rsp_t      rsp_o
);
  localparam int AW = $clog2(Capacity);
  localparam int PW = AW + 1;
  localparam int XW = (PW > 13) ? PW : 13;
  localparam logic [PW-1:0] CapP = PW'(Capacity);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SMoveR = 3'd1;
  localparam logic [2:0] SMoveW = 3'd2;
  localparam logic [2:0] SApply = 3'd3;
  localparam logic [2:0] SRdWt  = 3'd4;
  localparam logic [2:0] SScan  = 3'd5;
  localparam logic [2:0] SDone  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] gf_q, gf_d, ga_q, ga_d;
  gbts_req_t     req_q;
  logic [PW-1:0] tgt_q, tgt_d, hi_q, hi_d;
  logic [PW-1:0] cur_q, cur_d;
  logic [PW-1:0] src_q, src_d;
  logic          scan_rd_q, scan_rd_d;
  logic          out_v_q;
  gbts_rsp_t     out_q, res_d;
  logic          res_fire;

  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;

  logic [PW-1:0] len, lo_w, hi_w, gapw;
  logic [XW-1:0] pos_x, end_x, len_x;
  logic          take;

  gbts_ram #(.Width(8), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign len   = gf_q + (CapP - ga_q);
  assign gapw  = ga_q - gf_q;
  // compare request positions at a width that holds both sides
  assign pos_x = XW'(req_i.pos);
  assign end_x = XW'(req_i.range_end);
  assign len_x = XW'(len);
  assign lo_w  = (pos_x < len_x) ? PW'(pos_x) : len;
  assign hi_w  = (end_x < len_x) ? PW'(end_x) : len;
  assign take  = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != SIdle) || (out_v_q && rsp_stall_i);

  // physical address of a logical position
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] p, input logic [PW-1:0] gf,
                                         input logic [PW-1:0] gw);
    phys = (p < gf) ? p : p + gw;
  endfunction

  // sequencer
  always_comb begin
    state_d = state_q; gf_d = gf_q; ga_d = ga_q; tgt_d = tgt_q; hi_d = hi_q;
    cur_d = cur_q; src_d = src_q; scan_rd_d = 1'b0;
    we = 1'b0; addr = '0; wdata = rdata; res_fire = 1'b0;
    res_d = '0;
    res_d.text_length = 13'(len);
    unique case (state_q)
      SIdle: begin
        if (take) begin
          unique case (req_i.op)
            OpInsert: begin
              if (pos_x > len_x) begin
                res_d.status = StBeyond; res_fire = 1'b1; state_d = SDone;
              end else if (gf_q == ga_q) begin
                res_d.status = StFull; res_fire = 1'b1; state_d = SDone;
              end else begin
                tgt_d = lo_w; state_d = SMoveR;
              end
            end
            OpDelete: begin
              if (hi_w > lo_w) begin
                tgt_d = lo_w; hi_d = hi_w; state_d = SMoveR;
              end else begin
                res_fire = 1'b1; state_d = SDone;
              end
            end
            OpRead: begin
              if (pos_x < len_x) begin
                addr = AW'(phys(lo_w, gf_q, gapw)); state_d = SRdWt;
              end else begin
                res_fire = 1'b1; state_d = SDone;
              end
            end
            OpFindFwd: begin
              cur_d = lo_w; state_d = SScan;
            end
            OpFindRev: begin
              cur_d = lo_w; state_d = SScan;
            end
            OpClear: begin
              gf_d = '0; ga_d = CapP;
              res_d.text_length = '0; res_fire = 1'b1; state_d = SDone;
            end
            default: begin
              res_fire = 1'b1; state_d = SDone;
            end
          endcase
        end
      end
      SMoveR: begin
        // read one byte that crosses the gap
        if (tgt_q < gf_q) begin
          addr = AW'(gf_q - 1'b1); src_d = ga_q - 1'b1; state_d = SMoveW;
        end else if (tgt_q > gf_q) begin
          addr = AW'(ga_q); src_d = gf_q; state_d = SMoveW;
        end else begin
          state_d = SApply;
        end
      end
      SMoveW: begin
        we = 1'b1; addr = AW'(src_q); wdata = rdata;
        if (tgt_q < gf_q) begin
          gf_d = gf_q - 1'b1; ga_d = ga_q - 1'b1;
        end else begin
          gf_d = gf_q + 1'b1; ga_d = ga_q + 1'b1;
        end
        state_d = SMoveR;
      end
      SApply: begin
        if (req_q.op == OpInsert) begin
          we = 1'b1; addr = AW'(gf_q); wdata = req_q.byte_in;
          gf_d = gf_q + 1'b1;
          res_d.text_length = 13'(len + 1'b1);
        end else begin
          ga_d = ga_q + (hi_q - tgt_q);
          res_d.text_length = 13'(len - (hi_q - tgt_q));
        end
        res_fire = 1'b1; state_d = SDone;
      end
      SRdWt: begin
        res_d.read_byte = rdata; res_fire = 1'b1; state_d = SDone;
      end
      SScan: begin
        // check the byte read last cycle, then issue the next read
        res_d.found_pos = 13'(len);
        if (scan_rd_q && rdata == req_q.byte_in) begin
          res_d.found = 1'b1;
          res_d.found_pos = (req_q.op == OpFindFwd) ? 13'(cur_q - 1'b1) : 13'(cur_q);
          res_fire = 1'b1; state_d = SDone;
        end else if (req_q.op == OpFindFwd) begin
          if (cur_q < len) begin
            addr = AW'(phys(cur_q, gf_q, gapw)); cur_d = cur_q + 1'b1; scan_rd_d = 1'b1;
          end else begin
            res_fire = 1'b1; state_d = SDone;
          end
        end else begin
          if (cur_q != '0) begin
            addr = AW'(phys(cur_q - 1'b1, gf_q, gapw)); cur_d = cur_q - 1'b1;
            scan_rd_d = 1'b1;
          end else begin
            res_fire = 1'b1; state_d = SDone;
          end
        end
      end
      SDone: begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; gf_q <= '0; ga_q <= CapP; out_v_q <= 1'b0; scan_rd_q <= 1'b0;
    end else begin
      state_q <= state_d; gf_q <= gf_d; ga_q <= ga_d; scan_rd_q <= scan_rd_d;
      if (res_fire) begin
        out_v_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req_i;
    end
    tgt_q <= tgt_d; hi_q <= hi_d; cur_q <= cur_d; src_q <= src_d;
    if (res_fire) begin
      out_q <= res_d;
    end
  end

  assign rsp_valid_o = out_v_q;
  assign rsp_o = out_q;

  // gap never inverts
  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni) gf_q <= ga_q)
    else $error("gap bounds crossed");
  // a result is only produced while a request is in work
  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |-> (state_q != SDone))
    else $error("result without request");
  // output held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && rsp_stall_i |=> out_v_q)
    else $error("result dropped");
endmodule
`default_nettype wire
